// ----- hdl/abrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrb_pkg
// Shared types, constants and helper functions for the audio byte ring buffer.
// ----------------------------------------------------------------------------
package abrb_pkg;

    localparam int DEPTH   = 4096;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = ADDR_W + 1;
    localparam int IDX_W   = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Operation codes.
    localparam logic [2:0] OP_PUSH8  = 3'd0;
    localparam logic [2:0] OP_PUSH16 = 3'd1;
    localparam logic [2:0] OP_POP8   = 3'd2;
    localparam logic [2:0] OP_POP16  = 3'd3;
    localparam logic [2:0] OP_FLUSH  = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Register map.
    localparam logic       REG_SIZE_LOG2 = 1'b0;
    localparam logic [3:0] SIZE_LOG2_RST = 4'd12;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] data_in;
    } abrb_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [15:0]       data_out;
        logic [FILL_W-1:0] fill_level;
    } abrb_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_req;   // capture the request and judge it
        logic mem_we;    // write one byte to the store
        logic addr_rd;   // address from the read index, else the write index
        logic addr_inc;  // address the byte after the index
        logic wr_hi;     // write the high byte of the sample, else the low byte
        logic cap_hi;    // store read data as the high byte of the result
        logic cap_lo;    // store read data as the low byte of the result
        logic adv;       // move the indices for the finished operation
        logic load_rsp;  // load the output register
    } abrb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       ok;
    } abrb_stat_t;

    // Buffer size in bytes: 2^lg, raised to at least two and limited to DEPTH.
    function automatic logic [FILL_W-1:0] buf_size(input logic [3:0] lg);
        logic [FILL_W-1:0] s;
        if (lg >= 4'(ADDR_W))
            s = FILL_W'(DEPTH);
        else if (lg == 4'd0)
            s = FILL_W'(2);
        else
            s = FILL_W'(1) << lg;
        return s;
    endfunction

    function automatic logic [ADDR_W-1:0] buf_mask(input logic [3:0] lg);
        logic [FILL_W-1:0] s;
        s = buf_size(lg) - FILL_W'(1);
        return s[ADDR_W-1:0];
    endfunction

endpackage

// ----- hdl/abrb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrb_ram
// Generic single-port RAM with one write or read per cycle and registered read.
// ----------------------------------------------------------------------------
module abrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/abrb_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrb_dp
// Datapath: indices, size register, byte store, result assembly.
// ----------------------------------------------------------------------------
module abrb_dp
    import abrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  abrb_req_t  req,
    input  abrb_cmd_t  cmd,
    input  logic       cfg_we,
    input  logic [3:0] cfg_size_log2,
    output logic [3:0] size_log2,
    output abrb_stat_t stat,
    output abrb_rsp_t  rsp
);

    logic [IDX_W-1:0]  ri_reg, ri_next;
    logic [IDX_W-1:0]  wi_reg, wi_next;
    logic [3:0]        size_log2_reg;
    logic [2:0]        op_reg;
    logic [15:0]       data_reg;
    logic [1:0]        status_reg, status_next;
    logic [15:0]       dout_reg;
    abrb_rsp_t         rsp_reg;

    logic [FILL_W-1:0] size;
    logic [ADDR_W-1:0] mask;
    logic [IDX_W-1:0]  fill;
    logic [IDX_W-1:0]  base;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic [7:0]        rdata;
    logic              ok;

    assign size = buf_size(size_log2_reg);
    assign mask = buf_mask(size_log2_reg);
    assign fill = wi_reg - ri_reg;
    assign ok   = (status_reg == ST_OK);

    // Judge the request against the fill level as it stands on acceptance.
    always_comb
    begin
        status_next = ST_OK;
        unique case (req.opcode)
            OP_PUSH8:
                if (fill >= IDX_W'(size))
                    status_next = ST_FULL;
            OP_PUSH16:
                if ((IDX_W+1)'(fill) + (IDX_W+1)'(2) > (IDX_W+1)'(size))
                    status_next = ST_FULL;
            OP_POP8:
                if (fill == '0)
                    status_next = ST_EMPTY;
            OP_POP16:
                if (fill < IDX_W'(2))
                    status_next = ST_EMPTY;
            default:
                status_next = ST_OK;
        endcase
    end

    always_comb
    begin
        ri_next = ri_reg;
        wi_next = wi_reg;
        if (cfg_we)
        begin
            ri_next = '0;
            wi_next = '0;
        end
        else if (cmd.adv && ok)
        begin
            unique case (op_reg)
                OP_PUSH8:  wi_next = wi_reg + IDX_W'(1);
                OP_PUSH16: wi_next = wi_reg + IDX_W'(2);
                OP_POP8:   ri_next = ri_reg + IDX_W'(1);
                OP_POP16:  ri_next = ri_reg + IDX_W'(2);
                OP_FLUSH:
                begin
                    ri_next = '0;
                    wi_next = '0;
                end
                default:
                begin
                    ri_next = ri_reg;
                    wi_next = wi_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ri_reg        <= '0;
            wi_reg        <= '0;
            size_log2_reg <= SIZE_LOG2_RST;
        end
        else
        begin
            ri_reg <= ri_next;
            wi_reg <= wi_next;
            if (cfg_we)
            begin
                size_log2_reg <= cfg_size_log2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            op_reg     <= req.opcode;
            data_reg   <= req.data_in;
            status_reg <= status_next;
            dout_reg   <= '0;
        end
        else
        begin
            if (cmd.cap_hi)
                dout_reg[15:8] <= rdata;
            if (cmd.cap_lo)
                dout_reg[7:0] <= rdata;
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.status     <= status_reg;
            rsp_reg.data_out   <= dout_reg;
            rsp_reg.fill_level <= fill[FILL_W-1:0];
        end
    end

    assign base  = cmd.addr_rd ? ri_reg : wi_reg;
    assign idx   = base + (cmd.addr_inc ? IDX_W'(1) : IDX_W'(0));
    assign addr  = idx[ADDR_W-1:0] & mask;
    assign wdata = cmd.wr_hi ? data_reg[15:8] : data_reg[7:0];

    abrb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.mem_we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign stat.op   = op_reg;
    assign stat.ok   = ok;
    assign size_log2 = size_log2_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- hdl/abrb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrb_ctrl
// Controller: sequences the byte accesses of one operation and owns the
// handshakes on both channels.
// ----------------------------------------------------------------------------
module abrb_ctrl
    import abrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  abrb_stat_t stat,
    output abrb_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP1  = 3'd1;
    localparam logic [2:0] S_OP2  = 3'd2;
    localparam logic [2:0] S_OP3  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.cap_req = 1'b1;
                    state_next  = S_OP1;
                end
            end
            S_OP1:
            begin
                if (stat.ok && stat.op == OP_PUSH8)
                begin
                    cmd.mem_we = 1'b1;
                    cmd.adv    = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.ok && stat.op == OP_PUSH16)
                begin
                    cmd.mem_we = 1'b1;
                    cmd.wr_hi  = 1'b1;
                    state_next = S_OP2;
                end
                else if (stat.ok && (stat.op == OP_POP8 || stat.op == OP_POP16))
                begin
                    cmd.addr_rd = 1'b1;
                    state_next  = S_OP2;
                end
                else
                begin
                    // Flush, refused operations and unused codes touch no byte.
                    cmd.adv    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_OP2:
            begin
                if (stat.op == OP_PUSH16)
                begin
                    cmd.mem_we   = 1'b1;
                    cmd.addr_inc = 1'b1;
                    cmd.adv      = 1'b1;
                    state_next   = S_DONE;
                end
                else if (stat.op == OP_POP8)
                begin
                    cmd.cap_lo = 1'b1;
                    cmd.adv    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    // The first byte of a sample is the high byte.
                    cmd.cap_hi   = 1'b1;
                    cmd.addr_rd  = 1'b1;
                    cmd.addr_inc = 1'b1;
                    state_next   = S_OP3;
                end
            end
            S_OP3:
            begin
                cmd.cap_lo = 1'b1;
                cmd.adv    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_rsp   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- hdl/audio_byte_ring_buffer_core.sv -----
`timescale 1ns / 1ps
// A byte push or pop writes or reads one byte, a sample push or pop the high byte
// and then the low byte; flush, refused and unused operations touch no byte. The
// single-port byte store takes one byte access per cycle, with a registered read.
// A word is taken once the last is finished; a finished word may wait in the
// output register while the next is taken. Reset (rst_n low, asynchronous)
// empties the buffer and sets size_log2 to 12; the store is not cleared.
// ----------------------------------------------------------------------------
// audio_byte_ring_buffer_core
// Byte-wide audio ring buffer with byte and sample push/pop and an APB port.
// ----------------------------------------------------------------------------
module audio_byte_ring_buffer_core
    import abrb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  abrb_req_t          req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output abrb_rsp_t          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    abrb_cmd_t  cmd;
    abrb_stat_t stat;
    logic       cfg_we;
    logic       sel_size;
    logic [3:0] size_log2;

    assign pready   = 1'b1;
    assign sel_size = (paddr[2] == REG_SIZE_LOG2);
    assign cfg_we   = psel && penable && pwrite && pready && sel_size;
    assign prdata   = sel_size ? PDATA_W'(size_log2) : '0;

    abrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    abrb_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_size_log2 (pwdata[3:0]),
        .size_log2     (size_log2),
        .stat          (stat),
        .rsp           (rsp)
    );

endmodule

// ----- hdl/abrb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrb_checker
// Port-level checks on the ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module abrb_checker
    import abrb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input abrb_rsp_t rsp
);

    // A stalled result word holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    // The block works on one word at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_FULL
                      || rsp.status == ST_EMPTY)
        else $error("undefined status code");

    // A refused operation returns no data.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.data_out == 16'd0)
        else $error("data returned with a refused operation");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.fill_level <= FILL_W'(DEPTH))
        else $error("fill level beyond the store depth");

endmodule

bind audio_byte_ring_buffer_core abrb_checker u_abrb_checker (.*);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte and sample pushes, pops, flushes and unused operations into the
// ring buffer over several buffer sizes, and compares every result word with
// a predicted copy of the buffer held in a small scoreboard.
// ----------------------------------------------------------------------------
module testbench;
    import abrb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 20;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [PADDR_W-1:0] SIZE_REG_ADDR = PADDR_W'(4 * REG_SIZE_LOG2);

    class ring_scoreboard;
        logic [7:0]  store [DEPTH];
        logic [15:0] rd_idx;
        logic [15:0] wr_idx;
        logic [3:0]  size_lg;
        abrb_rsp_t   pending_words[$];
        int          errors;
        int          words_checked;
        int          full_hits;
        int          empty_hits;

        function new();
            size_lg       = SIZE_LOG2_RST;
            rd_idx        = '0;
            wr_idx        = '0;
            errors        = 0;
            words_checked = 0;
            full_hits     = 0;
            empty_hits    = 0;
        endfunction

        function void set_size(input logic [3:0] lg);
            size_lg = lg;
            rd_idx  = '0;
            wr_idx  = '0;
        endfunction

        // Bytes in use: a power of two no smaller than two and no larger
        // than the store.
        function int unsigned capacity();
            int unsigned bytes;
            bytes = 32'd1 << size_lg;
            if (bytes < 2)
                bytes = 2;
            if (bytes > DEPTH)
                bytes = DEPTH;
            return bytes;
        endfunction

        function logic [ADDR_W-1:0] slot(input logic [15:0] idx);
            return idx[ADDR_W-1:0] & ADDR_W'(capacity() - 1);
        endfunction

        function int unsigned held();
            logic [15:0] diff;
            diff = wr_idx - rd_idx;
            return 32'(diff);
        endfunction

        function void flag(input string what);
            errors++;
            if (errors <= 10)
                $display("%s", what);
        endfunction

        function void note_word(input abrb_req_t w);
            abrb_rsp_t   r;
            int unsigned cap;
            int unsigned lvl;
            cap      = capacity();
            lvl      = held();
            r        = '0;
            r.status = ST_OK;
            case (w.opcode)
                OP_PUSH8:
                    if (lvl >= cap)
                        r.status = ST_FULL;
                    else
                    begin
                        store[slot(wr_idx)] = w.data_in[7:0];
                        wr_idx = wr_idx + 16'd1;
                    end
                OP_PUSH16:
                    if (lvl + 2 > cap)
                        r.status = ST_FULL;
                    else
                    begin
                        store[slot(wr_idx)] = w.data_in[15:8];
                        store[slot(wr_idx + 16'd1)] = w.data_in[7:0];
                        wr_idx = wr_idx + 16'd2;
                    end
                OP_POP8:
                    if (lvl < 1)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.data_out = {8'h00, store[slot(rd_idx)]};
                        rd_idx = rd_idx + 16'd1;
                    end
                OP_POP16:
                    if (lvl < 2)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.data_out = {store[slot(rd_idx)], store[slot(rd_idx + 16'd1)]};
                        rd_idx = rd_idx + 16'd2;
                    end
                OP_FLUSH:
                begin
                    rd_idx = '0;
                    wr_idx = '0;
                end
                default:
                    ;
            endcase
            r.fill_level = FILL_W'(held());
            if (r.status == ST_FULL)
                full_hits++;
            if (r.status == ST_EMPTY)
                empty_hits++;
            pending_words.push_back(r);
        endfunction

        function void check_word(input abrb_rsp_t got);
            abrb_rsp_t want;
            if (pending_words.size() == 0)
            begin
                flag($sformatf("Unexpected word: status %0d data %h fill %0d",
                               got.status, got.data_out, got.fill_level));
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (got.status !== want.status || got.data_out !== want.data_out ||
                got.fill_level !== want.fill_level)
                flag($sformatf({"Word %0d: expected status %0d data %h fill %0d, ",
                                "got status %0d data %h fill %0d"},
                               words_checked, want.status, want.data_out, want.fill_level,
                               got.status, got.data_out, got.fill_level));
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    abrb_req_t          req       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    abrb_rsp_t          rsp;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ring_scoreboard ring_sb;
    bit             tx_quiet  = 1'b0;
    bit             rx_quiet  = 1'b0;
    int             hold_req  = 0;
    int             cycles    = 0;

    audio_byte_ring_buffer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: a random stall before each word unless rx_quiet is set, and once a long
    // hold-off so that the buffer backs up into its input.
    initial
    begin
        int gap;
        ring_sb = new();
        forever
        begin
            if (hold_req > 0)
            begin
                gap      = hold_req;
                hold_req = 0;
            end
            else
                gap = rx_quiet ? 0 : $urandom_range(0, 6);
            repeat (gap) @(negedge clk) rsp_ready <= 1'b0;
            @(negedge clk) rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            ring_sb.check_word(rsp);
        end
    end

    task automatic do_op(input logic [2:0] op, input logic [15:0] d);
        abrb_req_t w;
        int        gap;
        w.opcode  = op;
        w.data_in = d;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        repeat (gap) @(negedge clk) req_valid <= 1'b0;
        @(negedge clk);
        req       <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        ring_sb.note_word(w);
    endtask

    task automatic wait_idle();
        @(negedge clk) req_valid <= 1'b0;
        while (ring_sb.pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic read_size_reg(input logic [3:0] lg);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SIZE_REG_ADDR;
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PDATA_W'(lg))
            ring_sb.flag($sformatf("Size register read %h, expected %h", prdata, lg));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // The size register may only change with the buffer idle, since the
    // write also clears both indices.
    task automatic set_buffer_size(input logic [3:0] lg);
        wait_idle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_REG_ADDR;
        pwdata  <= {(PDATA_W - 4)'($urandom), lg};
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        ring_sb.set_size(lg);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_size_reg(lg);
    endtask

    function automatic logic [2:0] pick_op(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return OP_FLUSH;
        if (r < 6)
            return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        r = $urandom_range(0, 99);
        if (filling ? (r < 72) : (r < 28))
            return $urandom_range(0, 1) ? OP_PUSH16 : OP_PUSH8;
        return $urandom_range(0, 1) ? OP_POP16 : OP_POP8;
    endfunction

    initial
    begin
        logic [3:0] phase_sizes [10];
        bit         filling;
        int         run_left;
        int         sizes_seen;
        phase_sizes = '{4'd0, 4'd2, 4'd3, 4'd12, 4'd15, 4'd4, 4'd13, 4'd5, 4'd1, 4'd8};
        sizes_seen  = 2;

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        read_size_reg(SIZE_LOG2_RST);

        // Empty pops, a sample pop with only one byte held, both data
        // extremes, the unused operations and a flush.
        do_op(OP_POP8, 16'hFFFF);
        do_op(OP_POP16, 16'h0000);
        do_op(OP_PUSH8, 16'hABFF);
        do_op(OP_POP16, 16'h0000);
        do_op(OP_PUSH16, 16'hFFFF);
        do_op(OP_PUSH16, 16'h0000);
        do_op(OP_POP8, 16'h0000);
        do_op(OP_POP16, 16'hFFFF);
        for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++)
            do_op(3'(k), 16'h5AA5);
        do_op(OP_PUSH8, 16'h1234);
        do_op(OP_FLUSH, 16'hFFFF);
        do_op(OP_POP8, 16'h0000);

        // Smallest buffer: full on a byte push, and a sample push refused
        // with only one byte free.
        set_buffer_size(4'd1);
        do_op(OP_PUSH8, 16'h0080);
        do_op(OP_PUSH8, 16'hFF01);
        do_op(OP_PUSH8, 16'h00FF);
        do_op(OP_PUSH16, 16'h1357);
        do_op(OP_POP16, 16'h0000);
        do_op(OP_PUSH16, 16'hC3A5);
        do_op(OP_PUSH16, 16'h2468);
        do_op(OP_POP8, 16'h0000);
        do_op(OP_PUSH16, 16'h8001);
        do_op(OP_PUSH8, 16'h007E);
        do_op(OP_POP16, 16'h0000);
        do_op(OP_POP8, 16'h0000);

        for (int p = 0; p < 10; p++)
        begin
            set_buffer_size(phase_sizes[p]);
            sizes_seen++;
            tx_quiet = (p % 4 == 1);
            rx_quiet = (p % 3 == 2);
            filling  = 1'b1;
            run_left = $urandom_range(4, 16);
            for (int i = 0; i < 70; i++)
            begin
                if (run_left == 0)
                begin
                    filling  = !filling;
                    run_left = $urandom_range(4, 16);
                end
                run_left--;
                do_op(pick_op(filling), 16'($urandom_range(0, 65535)));
            end
        end

        // Long receiver hold-off while the sender keeps offering words back
        // to back, then pop from what went in.
        set_buffer_size(4'd10);
        sizes_seen++;
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        hold_req = LONG_HOLD;
        for (int i = 0; i < 20; i++)
            do_op(OP_PUSH16, 16'($urandom_range(0, 65535)));
        tx_quiet = 1'b0;
        for (int i = 0; i < 20; i++)
            do_op($urandom_range(0, 1) ? OP_POP16 : OP_POP8, 16'h0000);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d result words over %0d size settings, in %0d cycles.",
                 ring_sb.words_checked, sizes_seen, cycles);
        $display("Refused as full %0d times and as empty %0d times; %0d mismatches.",
                 ring_sb.full_hits, ring_sb.empty_hits, ring_sb.errors);
        if (ring_sb.errors == 0 && ring_sb.pending_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
